// ===== sv/swbox_pkg.sv =====
// Shared types and constants for the swept box obstacle clip block.
// No dependencies; imported by every module of the block.
package swbox_pkg;

  localparam int MAX_OBSTACLES = 64;
  localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);

  localparam int ENTRY_W = 6;
  localparam int COORD_W = 32;
  localparam int SIZE_W = 31;
  localparam int WIDE_W = 64;
  localparam int PROD_W = 2 * WIDE_W;
  localparam int HALF_W = WIDE_W / 2;
  localparam int DEADBAND_W = 16;
  localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 16'd6;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_DEADBAND = 1'b0;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam int SIDE_RIGHT = 0;
  localparam int SIDE_LEFT = 1;
  localparam int SIDE_BOTTOM = 2;
  localparam int SIDE_TOP = 3;

  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_CLEAR,
    OP_QUERY,
    OP_NOP
  } op_t;

  // one queued request, start point already worked out
  typedef struct packed {
    op_t                       op;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [SIZE_W-1:0]         size_w;
    logic [SIZE_W-1:0]         size_h;
    logic signed [COORD_W-1:0] move_x;
    logic signed [COORD_W-1:0] move_y;
    logic                      solid;
    logic signed [COORD_W:0]   start_x;
    logic signed [COORD_W:0]   start_y;
  } req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
    logic                      solid;
  } obstacle_t;

endpackage

// ===== sv/swbox_front.sv =====
// Front end: decodes the request kind, computes the start point and holds
// a two-entry request queue for the back end. Depends on swbox_pkg.
module swbox_front import swbox_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                kind,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic [SIZE_W-1:0]         size_w,
  input  logic [SIZE_W-1:0]         size_h,
  input  logic signed [COORD_W-1:0] move_x,
  input  logic signed [COORD_W-1:0] move_y,
  input  logic                      solid,
  output logic                      q_valid,
  input  logic                      q_pop,
  output req_t                      q_item
);

  req_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  req_t       req_in;
  logic       push;

  always_comb begin
    req_in = '0;
    case (kind)
      KIND_ADD:   req_in.op = OP_ADD;
      KIND_CLEAR: req_in.op = OP_CLEAR;
      KIND_QUERY: req_in.op = OP_QUERY;
      default:    req_in.op = OP_NOP;
    endcase
    req_in.pos_x = pos_x;
    req_in.pos_y = pos_y;
    req_in.size_w = size_w;
    req_in.size_h = size_h;
    req_in.move_x = move_x;
    req_in.move_y = move_y;
    req_in.solid = solid;
    req_in.start_x = (COORD_W+1)'(pos_x) - (COORD_W+1)'(move_x);
    req_in.start_y = (COORD_W+1)'(pos_y) - (COORD_W+1)'(move_y);
  end

  assign in_stall = (fill == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (fill != 2'd0);
  assign q_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== sv/swbox_divu.sv =====
// Unsigned restoring divider, 128-bit dividend by 64-bit divisor,
// one quotient bit per cycle. Depends on swbox_pkg.
module swbox_divu import swbox_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [PROD_W-1:0]   dividend,
  input  logic [WIDE_W-1:0]   divisor,
  output logic                done,
  output logic [WIDE_W-1:0]   quotient
);

  localparam int STEP_W = $clog2(PROD_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [PROD_W-1:0] dvd;
  logic [WIDE_W-1:0] dsr;
  logic [WIDE_W-1:0] rem;
  logic [WIDE_W:0]   rem_sh;
  logic              take;

  assign rem_sh = {rem, dvd[PROD_W-1]};
  assign take = (rem_sh >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        dvd <= dividend;
        dsr <= divisor;
        rem <= '0;
      end else if (busy) begin
        dvd <= dvd << 1;
        quotient <= {quotient[WIDE_W-2:0], take};
        // remainder stays below the divisor, so it fits back in 64 bits
        if (take) begin
          rem <= WIDE_W'(rem_sh - {1'b0, dsr});
        end else begin
          rem <= WIDE_W'(rem_sh);
        end
        step <= step + 1'b1;
        if (step == STEP_W'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/swbox_back.sv =====
// Back end: obstacle table memory, table count and the clip sequencer
// that walks the table per query. Depends on swbox_pkg and swbox_divu.
module swbox_back import swbox_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [DEADBAND_W-1:0]     deadband,
  input  logic                      q_valid,
  input  req_t                      q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ENTRY_W-1:0]        entry_index,
  output logic                      table_full,
  output logic signed [COORD_W-1:0] new_x,
  output logic signed [COORD_W-1:0] new_y,
  output logic signed [COORD_W-1:0] new_move_x,
  output logic signed [COORD_W-1:0] new_move_y,
  output logic [3:0]                hit_sides
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_INIT, ST_FETCH, ST_LOAD, ST_YDIR, ST_XDIR, ST_NEXT,
    ST_SETUP, ST_MINMAX, ST_CHECK, ST_MAG, ST_MUL, ST_DIVS, ST_DIVW,
    ST_SUM, ST_RANGE, ST_APPLY, ST_APPLY2, ST_ADV, ST_DONE
  } state_t;

  state_t state;

  obstacle_t mem [MAX_OBSTACLES];
  obstacle_t rd;
  logic      wr_en;
  logic      rd_en;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] k;

  wide_t tx, ty, dx, dy, sx, sy, sxw, syh, bw, bh;
  wide_t ox, oy, ex, ey;
  logic [3:0] sides;
  logic [ENTRY_W-1:0] res_idx;
  logic res_full;

  logic phase_x, dir_pos, slot, vert;
  wide_t ofx, ofy;
  wide_t x1, y1, x2, y2, x3, y3, x4, y4;
  wide_t lox, hix, loy, hiy;
  wide_t md_a, md_b, md_c, md_d;
  logic [WIDE_W-1:0] mb, mc, md;
  logic neg;
  wide_t cx, cy;
  logic [PROD_W-1:0] acc;
  logic [2:0] mcnt;
  logic [1:0] pidx;
  logic [1:0] prod_idx;
  logic [WIDE_W-1:0] prod;

  wide_t dl, ndl;
  wide_t ofx_c, ofy_c;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [WIDE_W-1:0] mul_p;
  logic [PROD_W-1:0] prod_sh;
  logic [3:0] side_bit;
  logic div_start, div_done;
  logic [WIDE_W-1:0] quot;
  wide_t sum_val;

  assign dl = WIDE_W'({1'b0, deadband});
  assign ndl = -dl;

  assign wr_en = (state == ST_IDLE) && q_valid && (q_item.op == OP_ADD) &&
                 (cnt < CNT_W'(MAX_OBSTACLES));
  assign rd_en = (state == ST_FETCH) && (k < cnt);
  assign q_pop = (state == ST_IDLE) && q_valid;
  assign div_start = (state == ST_DIVS);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt[IDX_W-1:0]] <= '{x: q_item.pos_x, y: q_item.pos_y, w: q_item.size_w,
                               h: q_item.size_h, solid: q_item.solid};
    end
    if (rd_en) begin
      rd <= mem[k[IDX_W-1:0]];
    end
  end

  // leading corner offsets of the current path test
  always_comb begin
    if (!phase_x) begin
      ofx_c = slot ? bw : '0;
      ofy_c = dir_pos ? bh : '0;
    end else begin
      ofx_c = dir_pos ? bw : '0;
      ofy_c = slot ? bh : '0;
    end
    case ({phase_x, dir_pos})
      2'b01:   side_bit = 4'(1 << SIDE_BOTTOM);
      2'b00:   side_bit = 4'(1 << SIDE_TOP);
      2'b11:   side_bit = 4'(1 << SIDE_RIGHT);
      default: side_bit = 4'(1 << SIDE_LEFT);
    endcase
  end

  assign mul_a = pidx[1] ? mb[WIDE_W-1:HALF_W] : mb[HALF_W-1:0];
  assign mul_b = pidx[0] ? mc[WIDE_W-1:HALF_W] : mc[HALF_W-1:0];
  assign mul_p = mul_a * mul_b;

  // shift follows the index of the partial product held in prod
  always_comb begin
    case (prod_idx)
      2'd0:    prod_sh = PROD_W'(prod);
      2'd3:    prod_sh = PROD_W'(prod) << WIDE_W;
      default: prod_sh = PROD_W'(prod) << HALF_W;
    endcase
  end

  assign sum_val = neg ? md_a - wide_t'(quot) : md_a + wide_t'(quot);

  swbox_divu u_divu (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (md),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            tx <= '0; ty <= '0; dx <= '0; dy <= '0;
            sides <= '0;
            res_idx <= '0;
            res_full <= 1'b0;
            state <= ST_DONE;
            case (q_item.op)
              OP_ADD: begin
                if (cnt < CNT_W'(MAX_OBSTACLES)) begin
                  res_idx <= ENTRY_W'(cnt);
                  cnt <= cnt + 1'b1;
                end else begin
                  res_full <= 1'b1;
                end
              end
              OP_CLEAR: cnt <= '0;
              OP_QUERY: begin
                tx <= WIDE_W'(q_item.pos_x);
                ty <= WIDE_W'(q_item.pos_y);
                dx <= WIDE_W'(q_item.move_x);
                dy <= WIDE_W'(q_item.move_y);
                sx <= WIDE_W'(q_item.start_x);
                sy <= WIDE_W'(q_item.start_y);
                bw <= WIDE_W'({1'b0, q_item.size_w});
                bh <= WIDE_W'({1'b0, q_item.size_h});
                k <= '0;
                state <= ST_INIT;
              end
              default: ;
            endcase
          end
        end
        ST_INIT: begin
          sxw <= sx + bw;
          syh <= sy + bh;
          state <= ST_FETCH;
        end
        ST_FETCH: state <= (k < cnt) ? ST_LOAD : ST_DONE;
        ST_LOAD: begin
          ox <= WIDE_W'(rd.x);
          oy <= WIDE_W'(rd.y);
          ex <= WIDE_W'(rd.x) + WIDE_W'({1'b0, rd.w});
          ey <= WIDE_W'(rd.y) + WIDE_W'({1'b0, rd.h});
          state <= rd.solid ? ST_YDIR : ST_NEXT;
        end
        ST_YDIR: begin
          phase_x <= 1'b0;
          slot <= 1'b0;
          if (dy > dl) begin
            dir_pos <= 1'b1;
            // flush against the top edge at start
            if (syh == oy && sxw > ox && sx < ex) begin
              dy <= '0; ty <= sy; sides[SIDE_BOTTOM] <= 1'b1;
              state <= ST_XDIR;
            end else begin
              state <= ST_SETUP;
            end
          end else if (dy < ndl) begin
            dir_pos <= 1'b0;
            if (sy == ey && sxw > ox && sx < ex) begin
              dy <= '0; ty <= sy; sides[SIDE_TOP] <= 1'b1;
              state <= ST_XDIR;
            end else begin
              state <= ST_SETUP;
            end
          end else begin
            state <= ST_XDIR;
          end
        end
        ST_XDIR: begin
          phase_x <= 1'b1;
          slot <= 1'b0;
          if (dx > dl) begin
            dir_pos <= 1'b1;
            if (sxw == ox && syh > oy && sy < ey) begin
              dx <= '0; tx <= sx; sides[SIDE_RIGHT] <= 1'b1;
              state <= ST_NEXT;
            end else begin
              state <= ST_SETUP;
            end
          end else if (dx < ndl) begin
            dir_pos <= 1'b0;
            if (sx == ex && syh > oy && sy < ey) begin
              dx <= '0; tx <= sx; sides[SIDE_LEFT] <= 1'b1;
              state <= ST_NEXT;
            end else begin
              state <= ST_SETUP;
            end
          end else begin
            state <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          k <= k + 1'b1;
          state <= ST_FETCH;
        end
        ST_SETUP: begin
          ofx <= ofx_c;
          ofy <= ofy_c;
          x1 <= sx + ofx_c;
          y1 <= sy + ofy_c;
          // start plus move is the current target
          x2 <= tx + ofx_c;
          y2 <= ty + ofy_c;
          if (!phase_x) begin
            x3 <= ox; x4 <= ex;
            y3 <= dir_pos ? oy : ey;
            y4 <= dir_pos ? oy : ey;
          end else begin
            x3 <= dir_pos ? ox : ex;
            x4 <= dir_pos ? ox : ex;
            y3 <= oy; y4 <= ey;
          end
          state <= ST_MINMAX;
        end
        ST_MINMAX: begin
          lox <= (x1 < x2) ? x1 : x2;
          hix <= (x1 > x2) ? x1 : x2;
          loy <= (y1 < y2) ? y1 : y2;
          hiy <= (y1 > y2) ? y1 : y2;
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          // edges always run low to high, x3 <= x4 and y3 <= y4
          if (hix < x3 || hiy < y3 || lox > x4 || loy > y4) begin
            state <= ST_ADV;
          end else if (x3 == x4) begin
            vert <= 1'b1;
            if (x1 == x2 || !(lox < x3 && hix > x3)) begin
              state <= ST_ADV;
            end else begin
              cx <= x3;
              md_a <= y1; md_b <= y2 - y1; md_c <= x3 - x1; md_d <= x2 - x1;
              state <= ST_MAG;
            end
          end else begin
            vert <= 1'b0;
            if (y1 == y2 || !(loy <= y3 && hiy >= y3)) begin
              state <= ST_ADV;
            end else begin
              cy <= y3;
              if (y3 == y1) begin
                // tangent crossing: x stays at the path start
                cx <= x1;
                state <= ST_RANGE;
              end else begin
                md_a <= x1; md_b <= x2 - x1; md_c <= y3 - y1; md_d <= y2 - y1;
                state <= ST_MAG;
              end
            end
          end
        end
        ST_MAG: begin
          mb <= md_b[WIDE_W-1] ? WIDE_W'(-md_b) : WIDE_W'(md_b);
          mc <= md_c[WIDE_W-1] ? WIDE_W'(-md_c) : WIDE_W'(md_c);
          md <= md_d[WIDE_W-1] ? WIDE_W'(-md_d) : WIDE_W'(md_d);
          neg <= md_b[WIDE_W-1] ^ md_c[WIDE_W-1] ^ md_d[WIDE_W-1];
          acc <= '0;
          mcnt <= '0;
          pidx <= '0;
          if (md_b == '0 || md_c == '0 || md_d == '0) begin
            if (vert) cy <= md_a;
            else cx <= md_a;
            state <= ST_RANGE;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          // one 32x32 partial product per cycle, held in prod and then added into acc
          if (mcnt != 3'd4) begin
            prod <= mul_p;
            prod_idx <= pidx;
          end
          if (mcnt != 3'd0) begin
            acc <= acc + prod_sh;
          end
          if (mcnt == 3'd4) begin
            state <= ST_DIVS;
          end else begin
            pidx <= pidx + 1'b1;
          end
          mcnt <= mcnt + 1'b1;
        end
        ST_DIVS: state <= ST_DIVW;
        ST_DIVW: begin
          if (div_done) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (vert) cy <= sum_val;
          else cx <= sum_val;
          state <= ST_RANGE;
        end
        ST_RANGE: begin
          if (vert) begin
            state <= (cy >= y3 && cy <= y4) ? ST_APPLY : ST_ADV;
          end else begin
            state <= (cx >= x3 && cx <= x4) ? ST_APPLY : ST_ADV;
          end
        end
        ST_APPLY: begin
          tx <= cx - ofx;
          ty <= cy - ofy;
          sides <= sides | side_bit;
          state <= ST_APPLY2;
        end
        ST_APPLY2: begin
          dx <= tx - sx;
          dy <= ty - sy;
          state <= ST_ADV;
        end
        ST_ADV: begin
          if (!slot) begin
            slot <= 1'b1;
            state <= ST_SETUP;
          end else begin
            state <= phase_x ? ST_NEXT : ST_XDIR;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            entry_index <= res_idx;
            table_full <= res_full;
            new_x <= tx[COORD_W-1:0];
            new_y <= ty[COORD_W-1:0];
            new_move_x <= dx[COORD_W-1:0];
            new_move_y <= dy[COORD_W-1:0];
            hit_sides <= sides;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/swept_box_obstacle_clip.sv =====
// Add, clear or an unused kind go from idle straight to the output state.
// A query walks every stored obstacle, with up to 4 path tests per solid
// obstacle; the 128-step divider dominates a path test.
// The clip sequencer takes one request at a time; a two-entry
// request queue and an output register decouple both sides.
// Reset (rst, synchronous): table empty, queue empty, deadband = 6.
module swept_box_obstacle_clip import swbox_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                kind,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic [SIZE_W-1:0]         size_w,
  input  logic [SIZE_W-1:0]         size_h,
  input  logic signed [COORD_W-1:0] move_x,
  input  logic signed [COORD_W-1:0] move_y,
  input  logic                      solid,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ENTRY_W-1:0]        entry_index,
  output logic                      table_full,
  output logic signed [COORD_W-1:0] new_x,
  output logic signed [COORD_W-1:0] new_y,
  output logic signed [COORD_W-1:0] new_move_x,
  output logic signed [COORD_W-1:0] new_move_y,
  output logic [3:0]                hit_sides,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0]     pwdata,
  output logic [APB_DATA_W-1:0]     prdata,
  output logic                      pready
);

  logic [DEADBAND_W-1:0] deadband;
  logic                  q_valid;
  logic                  q_pop;
  req_t                  q_item;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DEADBAND) ? APB_DATA_W'(deadband) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= DEADBAND_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DEADBAND) begin
      deadband <= pwdata[DEADBAND_W-1:0];
    end
  end

  swbox_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .size_w   (size_w),
    .size_h   (size_h),
    .move_x   (move_x),
    .move_y   (move_y),
    .solid    (solid),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  swbox_back u_back (
    .clk         (clk),
    .rst         (rst),
    .deadband    (deadband),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .entry_index (entry_index),
    .table_full  (table_full),
    .new_x       (new_x),
    .new_y       (new_y),
    .new_move_x  (new_move_x),
    .new_move_y  (new_move_y),
    .hit_sides   (hit_sides)
  );

endmodule

// ===== sv/swbox_checker.sv =====
// Port-level checks for swept_box_obstacle_clip, attached by bind.
// Depends on swbox_pkg.
module swbox_checker import swbox_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [ENTRY_W-1:0]        entry_index,
  input logic                      table_full,
  input logic signed [COORD_W-1:0] new_x,
  input logic [3:0]                hit_sides,
  input logic                      pready
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_full_no_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> entry_index == '0 && hit_sides == '0 && new_x == '0)
    else $error("refused add carries data");

  a_ready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("config port not ready");

endmodule

bind swept_box_obstacle_clip swbox_checker u_swbox_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .entry_index (entry_index),
  .table_full  (table_full),
  .new_x       (new_x),
  .hit_sides   (hit_sides),
  .pready      (pready)
);

// ===== bench/swept_box_obstacle_clip_tb.sv =====
// Testbench for swept_box_obstacle_clip: obstacle table ops, swept box clipping, deadband register.
// Depends on swbox_pkg and the block's RTL. Results checked in order against an in-bench model.
`timescale 1ns / 100ps

module swept_box_obstacle_clip_tb;
  import swbox_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int MAX_SHOWN = 10;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [30:0]        size_w;
    logic [30:0]        size_h;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic               solid;
  } clip_req_t;

  typedef struct {
    logic [5:0]  entry_index;
    logic        table_full;
    logic [31:0] new_x;
    logic [31:0] new_y;
    logic [31:0] new_move_x;
    logic [31:0] new_move_y;
    logic [3:0]  hit_sides;
  } clip_result_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] kind = KIND_CLEAR;
  logic signed [31:0] pos_x = 0, pos_y = 0, move_x = 0, move_y = 0;
  logic [30:0] size_w = 0, size_h = 0;
  logic solid = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [5:0] entry_index;
  logic table_full;
  logic signed [31:0] new_x, new_y, new_move_x, new_move_y;
  logic [3:0] hit_sides;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [APB_ADDR_W-1:0] paddr = 0;
  logic [APB_DATA_W-1:0] pwdata = 0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  // model state
  longint obs_x[MAX_OBSTACLES];
  longint obs_y[MAX_OBSTACLES];
  longint obs_w[MAX_OBSTACLES];
  longint obs_h[MAX_OBSTACLES];
  bit     obs_solid[MAX_OBSTACLES];
  int     obs_count = 0;
  longint deadband = 6;

  clip_result_t pending_results[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;
  int items_sent = 0;

  swept_box_obstacle_clip uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    clip_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("%0t: unexpected result", $realtime);
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.entry_index !== entry_index || exp_r.table_full !== table_full ||
            exp_r.new_x !== new_x || exp_r.new_y !== new_y ||
            exp_r.new_move_x !== new_move_x || exp_r.new_move_y !== new_move_y ||
            exp_r.hit_sides !== hit_sides) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("%0t: mismatch exp idx=%0d full=%0b x=%h y=%h mx=%h my=%h sides=%b",
                     $realtime, exp_r.entry_index, exp_r.table_full, exp_r.new_x,
                     exp_r.new_y, exp_r.new_move_x, exp_r.new_move_y, exp_r.hit_sides);
            $display("%0t:          got idx=%0d full=%0b x=%h y=%h mx=%h my=%h sides=%b",
                     $realtime, entry_index, table_full, new_x, new_y, new_move_x,
                     new_move_y, hit_sides);
          end
        end
      end
    end
  end

  function automatic longint lmin(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic longint lmax(longint a, longint b);
    return a > b ? a : b;
  endfunction

  // a + (b*c)/d, exact product, truncated quotient
  function automatic longint scale_add(longint a, longint b, longint c, longint d);
    logic signed [127:0] bb, cc, dd, q;
    if (d == 0 || b == 0 || c == 0) return a;
    bb = b;
    cc = c;
    dd = d;
    q = (bb * cc) / dd;
    return a + $signed(q[63:0]);
  endfunction

  function automatic bit path_crosses(longint x1, longint y1, longint x2, longint y2,
                                      longint x3, longint y3, longint x4, longint y4,
                                      output longint cx, output longint cy);
    longint px, py;
    cx = 0;
    cy = 0;
    if (lmax(x1, x2) < lmin(x3, x4) || lmax(y1, y2) < lmin(y3, y4) ||
        lmin(x1, x2) > lmax(x3, x4) || lmin(y1, y2) > lmax(y3, y4)) return 0;
    if (x3 == x4) begin
      if (x1 == x2 || !(lmin(x1, x2) < x3 && lmax(x1, x2) > x3)) return 0;
      px = x3;
      py = scale_add(y1, y2 - y1, x3 - x1, x2 - x1);
      if (py < lmin(y3, y4) || py > lmax(y3, y4)) return 0;
    end else begin
      if (y1 == y2 || !(lmin(y1, y2) <= y3 && lmax(y1, y2) >= y3)) return 0;
      py = y3;
      // tangent start: crossing x is the start x
      px = (y3 == y1) ? x1 : scale_add(x1, x2 - x1, y3 - y1, y2 - y1);
      if (px < lmin(x3, x4) || px > lmax(x3, x4)) return 0;
    end
    cx = px;
    cy = py;
    return 1;
  endfunction

  function automatic void clip_obstacle(inout longint tx, inout longint ty,
                                        inout longint dx, inout longint dy,
                                        inout logic [3:0] sides,
                                        input longint ox, input longint oy,
                                        input longint ow, input longint oh,
                                        input longint bw, input longint bh);
    longint sx, sy, ex, ey, cx, cy;
    sx = tx - dx;
    sy = ty - dy;
    ex = ox + ow;
    ey = oy + oh;
    if (dy > deadband) begin
      if (sy + bh == oy && sx + bw > ox && sx < ex) begin
        dy = 0; ty = sy; sides[SIDE_BOTTOM] = 1;
      end else begin
        if (path_crosses(sx, sy + bh, sx + dx, sy + bh + dy, ox, oy, ex, oy, cx, cy)) begin
          tx = cx; ty = cy - bh; sides[SIDE_BOTTOM] = 1; dx = tx - sx; dy = ty - sy;
        end
        if (path_crosses(sx + bw, sy + bh, sx + dx + bw, sy + bh + dy, ox, oy, ex, oy,
                         cx, cy)) begin
          tx = cx - bw; ty = cy - bh; sides[SIDE_BOTTOM] = 1; dx = tx - sx; dy = ty - sy;
        end
      end
    end else if (dy < -deadband) begin
      if (sy == ey && sx + bw > ox && sx < ex) begin
        dy = 0; ty = sy; sides[SIDE_TOP] = 1;
      end else begin
        if (path_crosses(sx, sy, sx + dx, sy + dy, ox, ey, ex, ey, cx, cy)) begin
          tx = cx; ty = cy; sides[SIDE_TOP] = 1; dx = tx - sx; dy = ty - sy;
        end
        if (path_crosses(sx + bw, sy, sx + dx + bw, sy + dy, ox, ey, ex, ey, cx, cy)) begin
          tx = cx - bw; ty = cy; sides[SIDE_TOP] = 1; dx = tx - sx; dy = ty - sy;
        end
      end
    end
    if (dx > deadband) begin
      if (sx + bw == ox && sy + bh > oy && sy < ey) begin
        dx = 0; tx = sx; sides[SIDE_RIGHT] = 1;
      end else begin
        if (path_crosses(sx + bw, sy, sx + bw + dx, sy + dy, ox, oy, ox, ey, cx, cy)) begin
          tx = cx - bw; ty = cy; sides[SIDE_RIGHT] = 1; dx = tx - sx; dy = ty - sy;
        end
        if (path_crosses(sx + bw, sy + bh, sx + dx + bw, sy + bh + dy, ox, oy, ox, ey,
                         cx, cy)) begin
          tx = cx - bw; ty = cy - bh; sides[SIDE_RIGHT] = 1; dx = tx - sx; dy = ty - sy;
        end
      end
    end else if (dx < -deadband) begin
      if (sx == ex && sy + bh > oy && sy < ey) begin
        dx = 0; tx = sx; sides[SIDE_LEFT] = 1;
      end else begin
        if (path_crosses(sx, sy, sx + dx, sy + dy, ex, oy, ex, ey, cx, cy)) begin
          tx = cx; ty = cy; sides[SIDE_LEFT] = 1; dx = tx - sx; dy = ty - sy;
        end
        if (path_crosses(sx, sy + bh, sx + dx, sy + bh + dy, ex, oy, ex, ey, cx, cy)) begin
          tx = cx; ty = cy - bh; sides[SIDE_LEFT] = 1; dx = tx - sx; dy = ty - sy;
        end
      end
    end
  endfunction

  function automatic clip_result_t predict_request(clip_req_t r);
    clip_result_t res;
    longint tx, ty, dx, dy;
    logic [3:0] sides;
    res = '{default: '0};
    if (r.kind == KIND_ADD) begin
      if (obs_count < MAX_OBSTACLES) begin
        obs_x[obs_count] = r.pos_x;
        obs_y[obs_count] = r.pos_y;
        obs_w[obs_count] = longint'(r.size_w);
        obs_h[obs_count] = longint'(r.size_h);
        obs_solid[obs_count] = r.solid;
        res.entry_index = obs_count[5:0];
        obs_count++;
      end else res.table_full = 1;
    end else if (r.kind == KIND_CLEAR) begin
      obs_count = 0;
    end else if (r.kind == KIND_QUERY) begin
      tx = r.pos_x;
      ty = r.pos_y;
      dx = r.move_x;
      dy = r.move_y;
      sides = 0;
      for (int k = 0; k < obs_count; k++)
        if (obs_solid[k])
          clip_obstacle(tx, ty, dx, dy, sides, obs_x[k], obs_y[k], obs_w[k], obs_h[k],
                        longint'(r.size_w), longint'(r.size_h));
      res.new_x = tx[31:0];
      res.new_y = ty[31:0];
      res.new_move_x = dx[31:0];
      res.new_move_y = dy[31:0];
      res.hit_sides = sides;
    end
    return res;
  endfunction

  task automatic send_request(clip_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    kind <= r.kind;
    pos_x <= r.pos_x;
    pos_y <= r.pos_y;
    size_w <= r.size_w;
    size_h <= r.size_h;
    move_x <= r.move_x;
    move_y <= r.move_y;
    solid <= r.solid;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_request(r));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_deadband(logic [15:0] value);
    wait_drained();
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= APB_ADDR_W'(REG_DEADBAND) << 2;
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    deadband = longint'(value);
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] units(int n);
    return 32'(n) <<< 16;
  endfunction

  function automatic clip_req_t make_req(logic [1:0] k, logic signed [31:0] px,
                                         logic signed [31:0] py, logic [30:0] w,
                                         logic [30:0] h, logic signed [31:0] mx,
                                         logic signed [31:0] my, logic s);
    clip_req_t r;
    r.kind = k; r.pos_x = px; r.pos_y = py; r.size_w = w; r.size_h = h;
    r.move_x = mx; r.move_y = my; r.solid = s;
    return r;
  endfunction

  // query given the start point and the move
  task automatic send_query(int sx, int sy, int w, int h, logic signed [31:0] mx,
                            logic signed [31:0] my);
    send_request(make_req(KIND_QUERY, units(sx) + mx, units(sy) + my, 31'(units(w)),
                          31'(units(h)), mx, my, 0));
  endtask

  task automatic send_add(int x, int y, int w, int h, logic s);
    send_request(make_req(KIND_ADD, units(x), units(y), 31'(units(w)), 31'(units(h)),
                          0, 0, s));
  endtask

  function automatic clip_req_t noise_req();
    clip_req_t r;
    r.kind = 2'($urandom_range(3));
    r.pos_x = $urandom; r.pos_y = $urandom;
    r.size_w = 31'($urandom); r.size_h = 31'($urandom);
    r.move_x = $urandom; r.move_y = $urandom;
    r.solid = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic logic signed [31:0] rand_move();
    case ($urandom_range(5))
      0: return 0;
      1: return $signed($urandom_range(12)) - 6;  // around the deadband
      2: return units($urandom_range(12)) - units(6) + $signed($urandom_range(65535));
      default: return units($urandom_range(12)) - units(6);
    endcase
  endfunction

  task automatic test_table_ops();
    send_request(make_req(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(2'd3, 32'h7fffffff, 32'h80000000, '1, '1, 32'h7fffffff,
                          32'h80000000, 1));
    send_add(-2, -2, 1, 1, 0);
    send_request(make_req(KIND_ADD, 32'h80000000, 32'h7fffffff, '1, '0, 0, 0, 1));
    send_request(make_req(KIND_QUERY, 32'h7fffffff, 32'h80000000, '1, '1, 32'h7fffffff,
                          32'h80000000, 0));
    send_request(make_req(KIND_QUERY, 32'h80000000, 32'h7fffffff, 0, 0, 32'h80000000,
                          32'h7fffffff, 1));
    send_request(make_req(KIND_CLEAR, '1, '1, '1, '1, '1, '1, 1));
    // fill the table; only a few solid so the full-table query stays short
    for (int i = 0; i < MAX_OBSTACLES; i++)
      send_add(i * 3 - 90, 10, 2, 2, (i % 16) == 0);
    send_add(0, 0, 1, 1, 1);
    send_query(-90, 5, 1, 1, 0, units(8));
    send_request(make_req(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_collisions();
    send_add(10, 10, 10, 4, 1);       // block
    send_add(30, 0, 0, 20, 1);        // zero-width wall
    send_query(12, 4, 2, 2, 0, units(8));          // fall onto top
    send_query(12, 18, 2, 2, 0, -units(8));        // rise into bottom
    send_query(4, 11, 2, 2, units(10), 0);         // into left face
    send_query(24, 11, 2, 2, -units(10), units(1)); // into right face
    send_query(12, 8, 2, 2, units(1), units(3));    // resting on top
    send_query(20, 11, 2, 2, -units(3), 0);         // flush against right face
    send_query(8, 8, 2, 2, units(4), units(3));     // tangent start on top line
    send_query(25, 5, 2, 2, units(10), units(1));   // across zero-width wall
    send_query(5, 5, 2, 2, units(20), units(20));   // diagonal
    send_request(make_req(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic run_scene();
    int n_obs, n_q;
    if ($urandom_range(3) != 0) send_request(make_req(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    n_obs = $urandom_range(5, 1);
    for (int i = 0; i < n_obs; i++)
      send_add($urandom_range(24) - 12, $urandom_range(24) - 12, $urandom_range(8),
               $urandom_range(8, 1), $urandom_range(5) != 0);
    n_q = $urandom_range(6, 2);
    for (int i = 0; i < n_q; i++)
      send_query($urandom_range(24) - 12, $urandom_range(24) - 12, $urandom_range(4),
                 $urandom_range(4), rand_move(), rand_move());
  endtask

  task automatic test_deadband();
    write_deadband(16'd0);
    send_add(0, 10, 10, 2, 1);
    send_query(2, 5, 2, 2, 0, 32'sd1);
    send_query(2, 8, 2, 2, 32'sd1, units(3));
    write_deadband(16'hffff);
    send_query(2, 8, 2, 2, 0, 32'sd65535);
    send_query(2, 8, 2, 2, 0, 32'sd65536);
    write_deadband(16'($urandom));
    repeat (3) run_scene();
    write_deadband(DEADBAND_RST);
  endtask

  task automatic test_random(int idle_pct, int stall_p, int quota, bit pause_once);
    int start;
    wait_drained();
    send_idle_pct = idle_pct;
    stall_pct = stall_p;
    start = items_sent;
    while (items_sent - start < quota) begin
      if ($urandom_range(9) == 0) send_request(noise_req());
      else run_scene();
      if (pause_once && items_sent - start > quota / 2) begin
        pause_once = 0;
        wait_drained();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_table_ops();
    test_collisions();
    test_deadband();
    test_random(0, 0, 150, 0);
    test_random(81, 0, 150, 1);
    test_random(0, 81, 150, 0);
    write_deadband(16'($urandom_range(2000)));
    test_random(14, 14, 150, 0);
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/swbox_pkg.sv
sv/swbox_front.sv
sv/swbox_divu.sv
sv/swbox_back.sv
sv/swept_box_obstacle_clip.sv
sv/swbox_checker.sv
bench/swept_box_obstacle_clip_tb.sv
